FILE: hw/rtl/sliding_window_peak_hold_top_defines.svh
// Assertion macros shared by the peak-hold block.
`ifndef SLIDING_WINDOW_PEAK_HOLD_TOP_DEFINES_SVH
`define SLIDING_WINDOW_PEAK_HOLD_TOP_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define SWPH_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent in the cycle after the antecedent.
`define SWPH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/swph_pkg.sv
package swph_pkg;

  // Store depth and sample width.
  localparam int DEPTH       = 4096;
  localparam int SAMPLE_BITS = 24;
  localparam int HOLD_W      = 12;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int TDATA_W     = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int CMP_W       = (HOLD_W > IDX_W) ? HOLD_W : IDX_W;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [HOLD_W-1:0]             hold_t;

  // One RAM access: write port and read address.
  typedef struct packed {
    logic    we;
    idx_t    waddr;
    sample_t wdata;
    idx_t    raddr;
  } ram_req_t;

  // Status seen by the top level.
  typedef struct packed {
    logic busy;
    logic queue_empty;
  } ctrl_status_t;

endpackage

FILE: hw/rtl/swph_ram.sv
module swph_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

FILE: hw/rtl/swph_ctrl.sv
module swph_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  swph_pkg::hold_t         cfg_hold,
  input  logic                    in_take,
  input  swph_pkg::sample_t       in_sample,
  output logic                    idle,
  output swph_pkg::ram_req_t      hist_req,
  input  swph_pkg::sample_t       hist_rdata,
  output swph_pkg::ram_req_t      cand_req,
  input  swph_pkg::sample_t       cand_rdata,
  output logic                    res_valid,
  output swph_pkg::sample_t       res_peak,
  input  logic                    res_ready,
  output swph_pkg::ctrl_status_t  status
);
  import swph_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_FRONT    = 3'd1;
  localparam logic [2:0] S_BACK_RD  = 3'd2;
  localparam logic [2:0] S_BACK_CMP = 3'd3;
  localparam logic [2:0] S_PUSH     = 3'd4;
  localparam logic [2:0] S_OUT      = 3'd5;

  logic [2:0] state_r, state_nxt;
  hold_t      hold_r, hold_nxt;
  sample_t    x_r, x_nxt;
  idx_t       w_r, w_nxt;
  idx_t       head_r, head_nxt;
  idx_t       tail_r, tail_nxt;
  idx_t       filled_r, filled_nxt;
  logic       was_empty_r, was_empty_nxt;
  idx_t       len;
  logic [CMP_W-1:0] hold_ext;

  // Effective window length: zero acts as one, capped below the store depth.
  always_comb begin
    hold_ext = CMP_W'(hold_r);
    if (hold_r == '0) begin
      len = idx_t'(1);
    end else if (hold_ext > CMP_W'(DEPTH - 1)) begin
      len = idx_t'(DEPTH - 1);
    end else begin
      len = idx_t'(hold_ext);
    end
  end

  // Sequencer: front check, back pops one compare at a time, push, result.
  always_comb begin
    state_nxt     = state_r;
    hold_nxt      = hold_r;
    x_nxt         = x_r;
    w_nxt         = w_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    filled_nxt    = filled_r;
    was_empty_nxt = was_empty_r;
    hist_req      = '{we: 1'b0, waddr: w_r, wdata: x_r, raddr: w_r - len};
    cand_req      = '{we: 1'b0, waddr: tail_r, wdata: x_r, raddr: head_r};
    res_valid     = 1'b0;
    res_peak      = was_empty_r ? x_r : cand_rdata;
    unique case (state_r)
      S_IDLE: begin
        if (cfg_we) begin
          hold_nxt   = cfg_hold;
          w_nxt      = '0;
          head_nxt   = '0;
          tail_nxt   = '0;
          filled_nxt = '0;
        end else if (in_take) begin
          x_nxt = in_sample;
          if (filled_r >= len && head_r != tail_r) begin
            state_nxt = S_FRONT;
          end else begin
            state_nxt = S_BACK_RD;
          end
        end
      end
      S_FRONT: begin
        // The leaving sample retires the front candidate when they match.
        if (cand_rdata == hist_rdata) begin
          head_nxt = head_r + idx_t'(1);
        end
        state_nxt = S_BACK_RD;
      end
      S_BACK_RD: begin
        cand_req.raddr = tail_r - idx_t'(1);
        if (head_r == tail_r) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_BACK_CMP;
        end
      end
      S_BACK_CMP: begin
        if (cand_rdata < x_r) begin
          tail_nxt  = tail_r - idx_t'(1);
          state_nxt = S_BACK_RD;
        end else begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cand_req.we   = 1'b1;
        hist_req.we   = 1'b1;
        tail_nxt      = tail_r + idx_t'(1);
        w_nxt         = w_r + idx_t'(1);
        was_empty_nxt = (head_r == tail_r);
        if (filled_r < len) begin
          filled_nxt = filled_r + idx_t'(1);
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      hold_r   <= hold_t'(1);
      w_r      <= '0;
      head_r   <= '0;
      tail_r   <= '0;
      filled_r <= '0;
    end else begin
      state_r  <= state_nxt;
      hold_r   <= hold_nxt;
      w_r      <= w_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      filled_r <= filled_nxt;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    was_empty_r <= was_empty_nxt;
  end

  assign idle               = (state_r == S_IDLE);
  assign status.busy        = (state_r != S_IDLE);
  assign status.queue_empty = (head_r == tail_r);

endmodule

FILE: hw/rtl/sliding_window_peak_hold_top.sv
// Channel  Ports                          Payload
// in       in_tvalid/in_tready/in_tdata   sample, signed 24 bits
// out      out_tvalid/out_tready/out_tdata peak, signed 24 bits
// cfg      cfg_valid/cfg_ready/cfg_data   hold_frames, 12 bits
//
// Each item steps the sequencer from the idle state that accepts it through a front
// check once the window is full, back read and compare, push and result, plus one more
// back read and compare per dropped back candidate; the next item waits for idle.
// Reset is synchronous and active low; it empties the queue and sets a window of one.
// A finished result waits in the output register while the next item is accepted;
// the sequencer stalls only if a second result is ready first.
`include "sliding_window_peak_hold_top_defines.svh"

module sliding_window_peak_hold_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [swph_pkg::TDATA_W-1:0]  in_tdata,   // [23:0] sample
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [swph_pkg::TDATA_W-1:0]  out_tdata,  // [23:0] peak
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swph_pkg::HOLD_W-1:0]   cfg_data
);
  import swph_pkg::*;

  logic         idle;
  logic         cfg_we;
  logic         in_take;
  ram_req_t     hist_req;
  ram_req_t     cand_req;
  logic [SAMPLE_BITS-1:0] hist_rdata;
  logic [SAMPLE_BITS-1:0] cand_rdata;
  logic         res_valid;
  sample_t      res_peak;
  logic         res_ready;
  ctrl_status_t status;
  logic         out_valid_r;
  sample_t      out_peak_r;

  // Configuration has priority over a sample in the same idle cycle.
  assign cfg_ready = idle;
  assign in_tready = idle && !cfg_valid;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign in_take   = in_tvalid && in_tready;

  swph_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_hold   (cfg_data),
    .in_take    (in_take),
    .in_sample  (sample_t'(in_tdata[SAMPLE_BITS-1:0])),
    .idle       (idle),
    .hist_req   (hist_req),
    .hist_rdata (sample_t'(hist_rdata)),
    .cand_req   (cand_req),
    .cand_rdata (sample_t'(cand_rdata)),
    .res_valid  (res_valid),
    .res_peak   (res_peak),
    .res_ready  (res_ready),
    .status     (status)
  );

  // Delay line of past samples.
  swph_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_hist_ram (
    .clk   (clk),
    .we    (hist_req.we),
    .waddr (hist_req.waddr),
    .wdata (hist_req.wdata),
    .raddr (hist_req.raddr),
    .rdata (hist_rdata)
  );

  // Ring of candidate maxima.
  swph_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(DEPTH)) u_cand_ram (
    .clk   (clk),
    .we    (cand_req.we),
    .waddr (cand_req.waddr),
    .wdata (cand_req.wdata),
    .raddr (cand_req.raddr),
    .rdata (cand_rdata)
  );

  // Output register parts the sequencer from the result channel.
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_peak_r <= res_peak;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(unsigned'(out_peak_r));

  // A restart leaves the queue empty.
  `SWPH_ASSERT_NEXT(a_cfg_clears_queue, cfg_valid && cfg_ready, status.queue_empty, "queue not empty after restart")
  // The sequencer is busy once a sample transfer completes.
  `SWPH_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, status.busy && !in_tready, "ready after sample transfer")
  // The queue always holds at least the newest sample once a result is offered.
  `SWPH_ASSERT_SAME(a_queue_filled, res_valid, !status.queue_empty, "empty queue with a result")

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import swph_pkg::*;

  // Items left in the feed when idling stops for the final stretch.
  localparam int QUIET_TAIL = 250;

  // One pending entry: either a sample transfer or a window-length write.
  typedef struct {
    bit      is_hold;
    hold_t   hold;
    sample_t sample;
  } feed_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [HOLD_W-1:0]  cfg_data = '0;

  feed_t   sample_feed[$];
  sample_t peaks_due[$];
  int      error_count = 0;

  // Transfers seen at the last rising edge, read by the feed driver.
  logic in_taken = 1'b0;
  logic cfg_taken = 1'b0;

  // Idle knobs, redrawn at random while the test runs.
  int gap_pct = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  int knob_cycles = 0;

  // Shadow state of the peak-hold window.
  sample_t hist_mem[DEPTH];
  sample_t cand_mem[DEPTH];
  int      wr_ptr = 0;
  int      q_head = 0;
  int      q_tail = 0;
  int      n_valid = 0;
  hold_t   hold_reg = 1;

  sliding_window_peak_hold_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // A new window length empties the queue and the delay line.
  function automatic void restart_window(hold_t len);
    hold_reg = len;
    wr_ptr   = 0;
    q_head   = 0;
    q_tail   = 0;
    n_valid  = 0;
  endfunction

  // Pushes one sample through the candidate queue and returns the window peak.
  function automatic sample_t next_peak(sample_t x);
    int len;
    int pos;
    int back;
    int head;
    int tail;
    len = (hold_reg == 0) ? 1 : ((hold_reg > DEPTH - 1) ? DEPTH - 1 : int'(hold_reg));
    head = q_head;
    tail = q_tail;
    // The oldest sample leaves a full window; retire it if it is the front.
    if (n_valid >= len) begin
      pos = (wr_ptr + DEPTH - len) % DEPTH;
      if (head != tail && cand_mem[head] == hist_mem[pos]) head = (head + 1) % DEPTH;
    end
    // Smaller candidates at the back can never be the peak again.
    while (head != tail) begin
      back = (tail + DEPTH - 1) % DEPTH;
      if (cand_mem[back] >= x) break;
      tail = back;
    end
    cand_mem[tail] = x;
    tail = (tail + 1) % DEPTH;
    hist_mem[wr_ptr] = x;
    wr_ptr = (wr_ptr + 1) % DEPTH;
    if (n_valid < len) n_valid++;
    q_head = head;
    q_tail = tail;
    return cand_mem[head];
  endfunction

  function automatic void add_sample(sample_t x);
    feed_t f;
    f.is_hold = 1'b0;
    f.hold    = '0;
    f.sample  = x;
    sample_feed.insert(sample_feed.size(), f);
  endfunction

  function automatic void add_hold(hold_t h);
    feed_t f;
    f.is_hold = 1'b1;
    f.hold    = h;
    f.sample  = '0;
    sample_feed.insert(sample_feed.size(), f);
  endfunction

  // A window-length write followed by bursts of shaped random samples.
  function automatic void add_random_run(hold_t h, int count);
    int      mode;
    int      burst;
    int      step;
    sample_t level;
    add_hold(h);
    while (count > 0) begin
      mode  = $urandom_range(0, 4);
      burst = $urandom_range(1, 40);
      level = sample_t'($urandom);
      step  = $urandom_range(0, 3);
      for (int k = 0; k < burst && count > 0; k++) begin
        case (mode)
          0: add_sample(sample_t'($urandom));
          // Small alphabet gives many equal candidates.
          1: add_sample(sample_t'($urandom_range(0, 6)) - sample_t'(3));
          // Falling ramps grow the queue, rising ramps empty it.
          2: begin
            level = level - sample_t'(step);
            add_sample(level);
          end
          3: begin
            level = level + sample_t'(step);
            add_sample(level);
          end
          default: begin
            case ($urandom_range(0, 3))
              0: add_sample(sample_t'(24'h7FFFFF));
              1: add_sample(sample_t'(24'h800000));
              2: add_sample(sample_t'(0));
              default: add_sample(sample_t'(-1));
            endcase
          end
        endcase
        count--;
      end
    end
  endfunction

  // Change how often each side idles so that busy and quiet stretches alternate.
  always @(posedge clk) begin
    knob_cycles <= knob_cycles + 1;
    if (knob_cycles % 300 == 0) begin
      case ($urandom_range(0, 3))
        0: gap_pct <= 0;
        1: gap_pct <= 5;
        2: gap_pct <= 20;
        default: gap_pct <= 50;
      endcase
      case ($urandom_range(0, 3))
        0: stall_pct <= 0;
        1: stall_pct <= 5;
        2: stall_pct <= 20;
        default: stall_pct <= 50;
      endcase
    end
  end

  // Feed driver: samples and window writes, changed at the falling edge.
  always @(negedge clk) begin : feed_driver
    feed_t              nxt;
    logic               v_n;
    logic               c_n;
    logic [TDATA_W-1:0] d_n;
    logic [HOLD_W-1:0]  h_n;
    v_n = in_tvalid && !in_taken;
    c_n = cfg_valid && !cfg_taken;
    d_n = in_tdata;
    h_n = cfg_data;
    if (rst_n && !v_n && !c_n) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_feed.size() > 0) begin
        nxt = sample_feed[0];
        if (nxt.is_hold) begin
          // Window writes go in only once every peak has come back.
          if (peaks_due.size() == 0) begin
            c_n = 1'b1;
            h_n = nxt.hold;
            sample_feed.delete(0);
          end
        end else if (sample_feed.size() >= QUIET_TAIL &&
                     $urandom_range(0, 99) < gap_pct) begin
          gap_left = $urandom_range(0, 18);
        end else begin
          v_n = 1'b1;
          d_n = '0;
          d_n[SAMPLE_BITS-1:0] = nxt.sample;
          sample_feed.delete(0);
        end
      end
    end
    in_tvalid <= v_n;
    in_tdata  <= d_n;
    cfg_valid <= c_n;
    cfg_data  <= h_n;
  end

  // Result side back-pressure in random bursts.
  always @(negedge clk) begin : drain_driver
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (sample_feed.size() >= QUIET_TAIL && $urandom_range(0, 99) < stall_pct) begin
      stall_left = $urandom_range(0, 18);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: predict on each accepted transfer and check each returned peak.
  always @(posedge clk) begin : peak_monitor
    sample_t want;
    sample_t got;
    in_taken  <= rst_n && in_tvalid && in_tready;
    cfg_taken <= rst_n && cfg_valid && cfg_ready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[SAMPLE_BITS-1:0];
        if (peaks_due.size() == 0) begin
          $display("%0t: unexpected peak, expected none, got %0d", $time, got);
          error_count++;
        end else begin
          want = peaks_due[0];
          peaks_due.delete(0);
          if (got !== want) begin
            $display("%0t: peak mismatch, expected %0d, got %0d", $time, want, got);
            error_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) restart_window(cfg_data);
      if (in_tvalid && in_tready) begin
        peaks_due.insert(peaks_due.size(), next_peak(in_tdata[SAMPLE_BITS-1:0]));
      end
    end
  end

  initial begin
    // Reset window of one: the sample passes straight through.
    add_sample(sample_t'(24'h7FFFFF));
    add_sample(sample_t'(24'h800000));
    add_sample(sample_t'(0));
    add_sample(sample_t'(-1));
    add_sample(sample_t'(1));
    add_sample(sample_t'(24'h555555));
    add_sample(sample_t'(24'hAAAAAA));
    // Short window: equal values, a leaving front, extremes and a partial fill.
    add_hold(3);
    add_sample(sample_t'(5));
    add_sample(sample_t'(5));
    add_sample(sample_t'(5));
    add_sample(sample_t'(9));
    add_sample(sample_t'(2));
    add_sample(sample_t'(1));
    add_sample(sample_t'(0));
    add_sample(sample_t'(24'h800000));
    add_sample(sample_t'(24'h7FFFFF));
    add_sample(sample_t'(24'h7FFFFF));
    add_sample(sample_t'(-1));
    add_sample(sample_t'(-1));
    add_sample(sample_t'(-1));
    add_sample(sample_t'(4));
    add_sample(sample_t'(3));
    // Rewriting the same length must forget the earlier samples.
    add_hold(3);
    add_sample(sample_t'(-5));
    add_sample(sample_t'(-7));

    add_random_run(2, 80);
    add_random_run(1, 50);
    add_random_run(5, 100);
    add_random_run(3, 80);
    add_random_run(17, 100);
    add_random_run(64, 150);
    add_random_run(300, 350);
    add_random_run(hold_t'($urandom_range(1, 12)), 60);
    add_random_run(hold_t'($urandom_range(1, 12)), 60);
    add_random_run(hold_t'($urandom_range(13, 100)), 100);
    // Longest window, only partly filled.
    add_random_run(4095, 150);
    add_random_run(7, 100);

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (sample_feed.size() > 0 || in_tvalid || cfg_valid || peaks_due.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
    if (peaks_due.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog in case the block stops answering.
  initial begin
    #8_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

FILE: sliding_window_peak_hold_top.f
+incdir+hw/rtl
hw/rtl/swph_pkg.sv
hw/rtl/swph_ram.sv
hw/rtl/swph_ctrl.sv
hw/rtl/sliding_window_peak_hold_top.sv
tb/sv/testbench.sv
